// ===== hw/rtl/urpd_pkg.sv =====
// ----------------------------------------------------------------------------
// urpd_pkg: shared definitions for the reboot pattern detector
// Field widths, sync byte codes, baud constants and the baud switch codes.
// ----------------------------------------------------------------------------
package urpd_pkg;

    localparam int BAUD_W  = 22;
    localparam int BYTE_W  = 8;
    localparam int SYNC_W  = 8;
    localparam int OTHER_W = 3;

    typedef logic [BAUD_W-1:0]  baud_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [SYNC_W-1:0]  sync_cnt_t;
    typedef logic [OTHER_W-1:0] other_cnt_t;

    typedef enum logic [1:0] {
        SW_NONE    = 2'd0,
        SW_DROP    = 2'd1,
        SW_RESTORE = 2'd2
    } baud_switch_t;

    localparam byte_t SYNC_7F = 8'h7F;
    localparam byte_t SYNC_FE = 8'hFE;
    localparam byte_t SYNC_F8 = 8'hF8;
    localparam byte_t SYNC_E0 = 8'hE0;
    localparam byte_t SYNC_80 = 8'h80;
    localparam byte_t SYNC_00 = 8'h00;

    localparam baud_t BAUD_2400  = 22'd2400;
    localparam baud_t BAUD_4800  = 22'd4800;
    localparam baud_t BAUD_9600  = 22'd9600;
    localparam baud_t BAUD_14400 = 22'd14400;
    localparam baud_t BAUD_19200 = 22'd19200;
    localparam baud_t BAUD_RESET = BAUD_9600;

    localparam sync_cnt_t  SYNC_THRESH_7F = 8'd20;
    localparam sync_cnt_t  SYNC_THRESH    = 8'd30;
    localparam other_cnt_t OTHER_LIMIT    = 3'd4;

endpackage

// ===== hw/rtl/urpd_in_if.sv =====
// ----------------------------------------------------------------------------
// urpd_in_if: received byte channel
// Carries one received byte request with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface urpd_in_if;
    logic                 valid;
    logic                 ready;
    logic                 byte_received;
    urpd_pkg::byte_t      rx_byte;

    modport source (output valid, output byte_received, output rx_byte, input ready);
    modport sink   (input valid, input byte_received, input rx_byte, output ready);
endinterface

// ===== hw/rtl/urpd_out_if.sv =====
// ----------------------------------------------------------------------------
// urpd_out_if: result channel
// Carries the reboot request, baud switch code and baud rate for each byte.
// ----------------------------------------------------------------------------
interface urpd_out_if;
    logic                   valid;
    logic                   ready;
    logic                   reboot_request;
    urpd_pkg::baud_switch_t baud_switch;
    urpd_pkg::baud_t        uart_baud_now;

    modport source (output valid, output reboot_request, output baud_switch,
                    output uart_baud_now, input ready);
    modport sink   (input valid, input reboot_request, input baud_switch,
                    input uart_baud_now, output ready);
endinterface

// ===== hw/rtl/urpd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// urpd_cfg_if: configuration write channel
// Carries a write of the initial baud register with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface urpd_cfg_if;
    logic            valid;
    logic            ready;
    urpd_pkg::baud_t initial_baud;

    modport source (output valid, output initial_baud, input ready);
    modport sink   (input valid, input initial_baud, output ready);
endinterface

// ===== hw/rtl/uart_isp_reboot_pattern_detector.sv =====
// ----------------------------------------------------------------------------
// uart_isp_reboot_pattern_detector: boot loader sync flood detector
// Counts programmer sync bytes, requests a reboot when the sync count reaches the
// threshold for the byte and baud rate, and reports baud drops and restores.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle while the result side is not
// stalled: the byte lands in an input register, and a single pass of logic
// updates the counts and baud state while it loads the result register.
// A byte request is still accepted while a result waits to be taken, as long
// as the input register is free. A write of initial_baud loads the current baud
// rate and is always accepted; the user must make it only while the block is
// idle, and the block itself does not enforce this.
module uart_isp_reboot_pattern_detector (
    input  logic clk,
    input  logic rst_n,
    urpd_in_if.sink    item_in,
    urpd_out_if.source result,
    urpd_cfg_if.sink   cfg
);
    import urpd_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic         byte_received_reg;
    byte_t        rx_byte_reg;
    logic         out_valid_reg, out_valid_next;
    logic         reboot_request_reg;
    baud_switch_t baud_switch_reg;
    baud_t        uart_baud_now_reg;

    sync_cnt_t    sync_count_reg, sync_count_next;
    other_cnt_t   other_count_reg, other_count_next;
    baud_t        saved_baud_reg, saved_baud_next;
    baud_t        current_baud_reg, current_baud_next;
    logic         req_next;
    baud_switch_t sw_next;

    logic in_accept;
    logic advance;
    logic high_baud;
    logic match;

    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign in_accept = item_in.valid && item_in.ready;
    assign cfg.ready = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.reboot_request = reboot_request_reg;
    assign result.baud_switch    = baud_switch_reg;
    assign result.uart_baud_now  = uart_baud_now_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign high_baud = current_baud_reg > BAUD_19200;
    assign match = (rx_byte_reg inside {SYNC_7F, SYNC_80, SYNC_E0, SYNC_F8, SYNC_FE}) ||
                   ((rx_byte_reg == SYNC_00) && high_baud);

    always_comb
    begin
        sync_count_next   = sync_count_reg;
        other_count_next  = other_count_reg;
        saved_baud_next   = saved_baud_reg;
        current_baud_next = current_baud_reg;
        req_next          = 1'b0;
        sw_next           = SW_NONE;

        if (byte_received_reg)
        begin
            if (match)
            begin
                sync_count_next = sync_count_reg + 8'd1;
            end
            else
            begin
                other_count_next = other_count_reg + 3'd1;
            end

            if (other_count_next >= OTHER_LIMIT)
            begin
                other_count_next = '0;
                sync_count_next  = '0;
                if ((saved_baud_reg != '0) && (current_baud_reg == BAUD_2400))
                begin
                    current_baud_next = saved_baud_reg;
                    saved_baud_next   = '0;
                    sw_next           = SW_RESTORE;
                end
            end

            if ((sync_count_next >= SYNC_THRESH_7F) && (rx_byte_reg == SYNC_7F))
            begin
                req_next = 1'b1;
            end
            else if ((sync_count_next >= SYNC_THRESH) && (rx_byte_reg == SYNC_FE) &&
                     (current_baud_next == BAUD_4800))
            begin
                req_next = 1'b1;
            end
            else if ((sync_count_next >= SYNC_THRESH) && (rx_byte_reg == SYNC_F8) &&
                     (current_baud_next == BAUD_9600))
            begin
                req_next = 1'b1;
            end
            else if ((sync_count_next >= SYNC_THRESH) && (rx_byte_reg == SYNC_E0) &&
                     (current_baud_next == BAUD_14400))
            begin
                req_next = 1'b1;
            end
            else if ((sync_count_next >= SYNC_THRESH) && (rx_byte_reg == SYNC_80) &&
                     (current_baud_next == BAUD_19200))
            begin
                req_next = 1'b1;
            end
            else if ((sync_count_next >= SYNC_THRESH) && (rx_byte_reg == SYNC_00) &&
                     (current_baud_next > BAUD_19200))
            begin
                saved_baud_next   = current_baud_next;
                current_baud_next = BAUD_2400;
                sync_count_next   = '0;
                other_count_next  = '0;
                sw_next           = SW_DROP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            sync_count_reg   <= '0;
            other_count_reg  <= '0;
            saved_baud_reg   <= '0;
            current_baud_reg <= BAUD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                sync_count_reg   <= sync_count_next;
                other_count_reg  <= other_count_next;
                saved_baud_reg   <= saved_baud_next;
                current_baud_reg <= current_baud_next;
            end
            else if (cfg.valid)
            begin
                current_baud_reg <= cfg.initial_baud;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_received_reg <= item_in.byte_received;
            rx_byte_reg       <= item_in.rx_byte;
        end
        if (advance)
        begin
            reboot_request_reg <= req_next;
            baud_switch_reg    <= sw_next;
            uart_baud_now_reg  <= current_baud_next;
        end
    end

    // The input register only refuses a request while a result is stalled.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("input refused without a stalled result");

    // The count of other bytes is cleared before it can reach four.
    a_other_range: assert property (@(posedge clk) disable iff (!rst_n)
        other_count_reg < OTHER_LIMIT)
        else $error("other byte count out of range");

    // A reboot request never comes with a baud drop or restore.
    a_req_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && reboot_request_reg) |-> (baud_switch_reg == SW_NONE))
        else $error("reboot request with a baud switch");

    // A baud drop reports 2400 and leaves the old rate saved.
    a_drop_baud: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && (baud_switch_reg == SW_DROP) |->
        (uart_baud_now_reg == BAUD_2400) && (current_baud_reg == BAUD_2400) &&
        (saved_baud_reg != '0))
        else $error("baud drop state inconsistent");

endmodule

// ===== verif/urpd_reboot_checker.sv =====
// ----------------------------------------------------------------------------
// urpd_reboot_checker: result checker for the reboot pattern detector
// Watches the byte, result and configuration channels, keeps its own copy of
// the sync and other counts and the baud state, predicts one result for every
// accepted byte request, and compares each accepted result field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module urpd_reboot_checker
    import urpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic         byte_received,
    input  byte_t        rx_byte,
    input  logic         res_valid,
    input  logic         res_ready,
    input  logic         reboot_request,
    input  baud_switch_t baud_switch,
    input  baud_t        uart_baud_now,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  baud_t        initial_baud,
    output int           outstanding,
    output int           mismatches
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic         reboot;
        baud_switch_t sw;
        baud_t        baud;
    } detector_result_t;

    sync_cnt_t        sync_cnt   = '0;
    other_cnt_t       other_cnt  = '0;
    baud_t            saved_baud = '0;
    baud_t            cur_baud   = BAUD_RESET;
    detector_result_t predicted_results[$];
    detector_result_t oldest;
    int               result_index = 0;

    function automatic detector_result_t advance_detector(input logic received, input byte_t b);
        detector_result_t r;
        logic             fast;
        logic             hit;
        r.reboot = 1'b0;
        r.sw     = SW_NONE;
        if (received)
        begin
            fast = cur_baud > BAUD_19200;
            hit  = (b == SYNC_7F) || (b == SYNC_80) || (b == SYNC_E0) || (b == SYNC_F8) ||
                   (b == SYNC_FE) || (b == SYNC_00 && fast);
            if (hit)
                sync_cnt = sync_cnt + 1'b1;
            else
                other_cnt = other_cnt + 1'b1;

            if (other_cnt >= OTHER_LIMIT)
            begin
                other_cnt = '0;
                sync_cnt  = '0;
                if (saved_baud != '0 && cur_baud == BAUD_2400)
                begin
                    cur_baud   = saved_baud;
                    saved_baud = '0;
                    r.sw       = SW_RESTORE;
                end
            end

            if (sync_cnt >= SYNC_THRESH_7F && b == SYNC_7F)
                r.reboot = 1'b1;
            else if (sync_cnt >= SYNC_THRESH && b == SYNC_FE && cur_baud == BAUD_4800)
                r.reboot = 1'b1;
            else if (sync_cnt >= SYNC_THRESH && b == SYNC_F8 && cur_baud == BAUD_9600)
                r.reboot = 1'b1;
            else if (sync_cnt >= SYNC_THRESH && b == SYNC_E0 && cur_baud == BAUD_14400)
                r.reboot = 1'b1;
            else if (sync_cnt >= SYNC_THRESH && b == SYNC_80 && cur_baud == BAUD_19200)
                r.reboot = 1'b1;
            else if (sync_cnt >= SYNC_THRESH && b == SYNC_00 && cur_baud > BAUD_19200)
            begin
                saved_baud = cur_baud;
                cur_baud   = BAUD_2400;
                sync_cnt   = '0;
                other_cnt  = '0;
                r.sw       = SW_DROP;
            end
        end
        r.baud = cur_baud;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d: %s expected %0d, got %0d",
                         result_index, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_cnt   = '0;
            other_cnt  = '0;
            saved_baud = '0;
            cur_baud   = BAUD_RESET;
            predicted_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cur_baud = initial_baud;

            if (res_valid && res_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %0d: reboot %0d, switch %0d, baud %0d",
                                 result_index, reboot_request, baud_switch, uart_baud_now);
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    check_field("reboot_request", 32'(oldest.reboot), 32'(reboot_request));
                    check_field("baud_switch", 32'(oldest.sw), 32'(baud_switch));
                    check_field("uart_baud_now", 32'(oldest.baud), 32'(uart_baud_now));
                end
                result_index = result_index + 1;
            end

            if (in_valid && in_ready)
                predicted_results.push_back(advance_detector(byte_received, rx_byte));

            outstanding = predicted_results.size();
        end
    end

endmodule

// ===== verif/uart_isp_reboot_pattern_detector_tb.sv =====
// ----------------------------------------------------------------------------
// uart_isp_reboot_pattern_detector_tb: top of the reboot detector testbench
// Drives a short directed byte sequence and then floods of sync bytes mixed
// with noise over a range of baud settings, with random sender gaps and
// receiver stalls. A separate checker predicts and compares every result
// request; this module gives the verdict.
// ----------------------------------------------------------------------------
module uart_isp_reboot_pattern_detector_tb;
    import urpd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int PHASE_ITEMS    = 65;
    localparam int NUM_PHASES     = 11;
    localparam int LONG_PHASE     = 6;
    localparam int SLOW_PCT       = 84;
    localparam int LIGHT_PCT      = 16;

    typedef enum int {
        PACE_FULL,
        PACE_SLOW_SOURCE,
        PACE_SLOW_SINK,
        PACE_BOTH
    } pace_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   outstanding;
    int   mismatches;

    byte_t sync_codes [6] = '{SYNC_7F, SYNC_FE, SYNC_F8, SYNC_E0, SYNC_80, SYNC_00};
    baud_t phase_baud [NUM_PHASES] = '{BAUD_9600, BAUD_4800, BAUD_14400, BAUD_19200,
                                       22'd115200, BAUD_2400, 22'd1200, 22'd0,
                                       22'h3FFFFF, 22'd4000000, 22'd57600};
    byte_t phase_code [NUM_PHASES] = '{SYNC_F8, SYNC_FE, SYNC_E0, SYNC_80,
                                       SYNC_00, SYNC_7F, SYNC_7F, SYNC_FE,
                                       SYNC_00, SYNC_00, SYNC_00};

    urpd_in_if  item_ch ();
    urpd_out_if result_ch ();
    urpd_cfg_if cfg_ch ();

    uart_isp_reboot_pattern_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    urpd_reboot_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (item_ch.valid),
        .in_ready       (item_ch.ready),
        .byte_received  (item_ch.byte_received),
        .rx_byte        (item_ch.rx_byte),
        .res_valid      (result_ch.valid),
        .res_ready      (result_ch.ready),
        .reboot_request (result_ch.reboot_request),
        .baud_switch    (result_ch.baud_switch),
        .uart_baud_now  (result_ch.uart_baud_now),
        .cfg_valid      (cfg_ch.valid),
        .cfg_ready      (cfg_ch.ready),
        .initial_baud   (cfg_ch.initial_baud),
        .outstanding    (outstanding),
        .mismatches     (mismatches)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_pace(input int slot);
        case (pace_t'(slot % 4))
            PACE_FULL:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            PACE_SLOW_SOURCE:
            begin
                idle_pct  = SLOW_PCT;
                stall_pct = 0;
            end
            PACE_SLOW_SINK:
            begin
                idle_pct  = 0;
                stall_pct = SLOW_PCT;
            end
            default:
            begin
                idle_pct  = LIGHT_PCT;
                stall_pct = LIGHT_PCT;
            end
        endcase
    endtask

    task automatic send_byte(input logic received, input byte_t b);
        if ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        item_ch.valid         <= 1'b1;
        item_ch.byte_received <= received;
        item_ch.rx_byte       <= b;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_baud(input baud_t value);
        drain_results();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.initial_baud <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input byte_t preferred, input int target, input logic long_flood);
        int    sent;
        int    len;
        int    noise_pct;
        int    k;
        logic  received;
        byte_t code;
        sent = 0;
        while (sent < target)
        begin
            set_pace(sent / 50);
            if (long_flood || $urandom_range(99) < 75)
            begin
                code      = ($urandom_range(1) == 0) ? preferred : sync_codes[$urandom_range(5)];
                len       = long_flood ? 270 : $urandom_range(15, 45);
                noise_pct = long_flood ? 0 : 4;
                long_flood = 1'b0;
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < noise_pct)
                    begin
                        send_byte(1'b1, byte_t'($urandom));
                        sent++;
                    end
                    else if ($urandom_range(99) < 3)
                        send_byte(1'b0, byte_t'($urandom));
                    else
                    begin
                        send_byte(1'b1, code);
                        sent++;
                    end
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    received = ($urandom_range(99) < 85);
                    send_byte(received, byte_t'($urandom));
                    if (received)
                        sent++;
                end
            end
        end
    endtask

    initial
    begin
        int p;
        item_ch.valid         <= 1'b0;
        item_ch.byte_received <= 1'b0;
        item_ch.rx_byte       <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.initial_baud   <= '0;
        phase_baud[NUM_PHASES-1] = baud_t'($urandom_range(1200, 4000000));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        send_byte(1'b1, SYNC_7F);
        send_byte(1'b1, SYNC_FE);
        send_byte(1'b1, SYNC_F8);
        send_byte(1'b1, SYNC_E0);
        send_byte(1'b1, SYNC_80);
        send_byte(1'b1, SYNC_00);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'h01);
        send_byte(1'b1, 8'h7E);
        send_byte(1'b1, SYNC_7F);
        send_byte(1'b0, SYNC_7F);
        send_byte(1'b1, 8'hAA);
        send_byte(1'b1, 8'h55);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_baud(phase_baud[p]);
            run_traffic(phase_code[p], PHASE_ITEMS, p == LONG_PHASE);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
